### src/euclid_pkg.sv
package euclid_pkg;

  // Port widths (fixed by the stream format)
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes carried in s_tuser
  localparam logic OP_GCD = 1'b0;
  localparam logic OP_INV = 1'b1;

  // Status codes carried in m_tuser
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_GCD_ZEROS   = 3'd1;
  localparam status_t ST_ZERO_VALUE  = 3'd2;
  localparam status_t ST_MOD_NOT_POS = 3'd3;
  localparam status_t ST_NO_INVERSE  = 3'd4;

endpackage

### src/euclid_gcd_and_mod_inverse_unit.sv
// Run time: data dependent; Fibonacci operands are the worst case (one quotient bit
//   per Euclid step, about 1.44*WIDTH steps); one shared shift/compare/subtract datapath.
// Throughput: one word at a time; s_tready is high only while the sequencer is idle.
// The finished result waits in res until the output register is free, so a stalled
//   m_tready delays its hand-off and holds s_tready low.
// Reset: synchronous, active high; clears the sequencer and m_tvalid.
module euclid_gcd_and_mod_inverse_unit #(
  parameter int WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: value_a [63:0], value_b [127:64]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [2*euclid_pkg::DATA_W-1:0]    s_tdata,
  // s_tuser: op [0]
  input  logic                               s_tuser,
  // m_tdata: result [63:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [euclid_pkg::DATA_W-1:0]      m_tdata,
  // m_tuser: status [2:0]
  output logic [euclid_pkg::STATUS_W-1:0]    m_tuser
);

  import euclid_pkg::*;

  localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int TW = WIDTH + 1;   // signed Bezout coefficient, |t| <= modulus

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;  // remainder zero? else start a division
  localparam logic [2:0] S_ALIGN = 3'd2;  // shift divisor up to the dividend
  localparam logic [2:0] S_SUB   = 3'd3;  // restoring subtract, one quotient bit
  localparam logic [2:0] S_SWAP  = 3'd4;  // Euclid rotate, or fold reduced value
  localparam logic [2:0] S_FIX   = 3'd5;  // map coefficient into 0..m-1
  localparam logic [2:0] S_DONE  = 3'd6;  // hand result to output register

  // What the division loop is working on
  localparam logic [1:0] MODE_GCD = 2'd0;  // plain Euclid on magnitudes
  localparam logic [1:0] MODE_RED = 2'd1;  // |a| mod m before the inverse
  localparam logic [1:0] MODE_INV = 2'd2;  // extended Euclid on (m, u)

  logic [2:0]              state;
  logic [1:0]              mode;
  logic [WIDTH-1:0]        r0, r1, d, m;
  logic signed [TW-1:0]    t0, t1, dt;
  logic [KW-1:0]           k;
  logic                    neg_a;
  logic [WIDTH-1:0]        res;
  status_t                 st;

  // Input decode
  logic [WIDTH-1:0] in_a, in_b, abs_a, abs_b;
  logic             in_a_neg, in_b_neg;

  always_comb begin
    in_a     = s_tdata[WIDTH-1:0];
    in_b     = s_tdata[DATA_W+WIDTH-1:DATA_W];
    in_a_neg = in_a[WIDTH-1];
    in_b_neg = in_b[WIDTH-1];
    abs_a    = in_a_neg ? (-in_a) : in_a;
    abs_b    = in_b_neg ? (-in_b) : in_b;
  end

  // Shared datapath terms
  logic             fits_twice;   // 2*d <= r0
  logic             sub_ok;       // r0 >= d
  logic [WIDTH-1:0] u_red;        // reduced value folded for a negative operand
  logic signed [TW-1:0] t_fixed;

  always_comb begin
    fits_twice = {d, 1'b0} <= {1'b0, r0};
    sub_ok     = r0 >= d;
    u_red      = (neg_a && (r0 != '0)) ? (m - r0) : r0;
    t_fixed    = t0[TW-1] ? (t0 + $signed({1'b0, m})) : t0;
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_GCD;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE drives m_tvalid itself
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            neg_a <= in_a_neg;
            m     <= in_b;
            r0    <= abs_a;
            t0    <= '0;
            t1    <= TW'(1);
            res   <= '0;
            if (s_tuser == OP_GCD) begin
              r1   <= abs_b;
              mode <= MODE_GCD;
              if ((in_a == '0) && (in_b == '0)) begin
                st    <= ST_GCD_ZEROS;
                state <= S_DONE;
              end else begin
                state <= S_CHECK;
              end
            end else begin
              r1   <= in_b;
              mode <= MODE_RED;
              if (in_a == '0) begin
                st    <= ST_ZERO_VALUE;
                state <= S_DONE;
              end else if ((in_b == '0) || in_b_neg) begin
                st    <= ST_MOD_NOT_POS;
                state <= S_DONE;
              end else begin
                state <= S_CHECK;
              end
            end
          end
        end
        S_CHECK: begin
          if (r1 == '0) begin
            if (mode == MODE_INV) begin
              state <= S_FIX;
            end else begin
              res   <= r0;
              st    <= ST_OK;
              state <= S_DONE;
            end
          end else begin
            d     <= r1;
            dt    <= t1;
            k     <= '0;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (fits_twice) begin
            d  <= {d[WIDTH-2:0], 1'b0};
            dt <= dt <<< 1;
            k  <= k + KW'(1);
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (sub_ok) begin
            r0 <= r0 - d;
            t0 <= t0 - dt;
          end
          d  <= d >> 1;
          dt <= dt >>> 1;
          if (k == '0) begin
            state <= S_SWAP;
          end else begin
            k <= k - KW'(1);
          end
        end
        S_SWAP: begin
          if (mode == MODE_RED) begin
            if (u_red == '0) begin
              // value is a multiple of m: only m of one has an inverse (zero)
              st    <= (m == WIDTH'(1)) ? ST_OK : ST_NO_INVERSE;
              state <= S_DONE;
            end else begin
              r0    <= m;
              r1    <= u_red;
              t0    <= '0;
              t1    <= TW'(1);
              mode  <= MODE_INV;
              state <= S_CHECK;
            end
          end else begin
            r0    <= r1;
            r1    <= r0;
            t0    <= t1;
            t1    <= t0;
            state <= S_CHECK;
          end
        end
        S_FIX: begin
          if (r0 == WIDTH'(1)) begin
            res <= t_fixed[WIDTH-1:0];
            st  <= ST_OK;
          end else begin
            res <= '0;
            st  <= ST_NO_INVERSE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= DATA_W'(res);
            m_tuser  <= st;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
